// ----- sv/k_way_sorted_merge_assert.svh -----
// Assertion macros for the k-way sorted merge block.
// Included by the top level; expects a clock named clk and a reset named rst.
`ifndef K_WAY_SORTED_MERGE_ASSERT_SVH
`define K_WAY_SORTED_MERGE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define KWSM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kwsm: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define KWSM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kwsm: next-cycle check failed");

`endif

// ----- sv/kwsm_pkg.sv -----
// Shared constants and controller/datapath handshake types for the merge block.
// No dependencies.
`timescale 1ns / 1ps

package kwsm_pkg;

  localparam int LANES      = 4;
  localparam int LANE_DEPTH = 16;
  localparam int LANE_W     = 2;
  localparam int VALUE_W    = 32;
  localparam int LANE_IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int PTR_W      = $clog2(LANE_DEPTH);
  localparam int CNT_W      = $clog2(LANE_DEPTH + 1);
  localparam int ADDR_W     = LANE_IDX_W + PTR_W;
  localparam int MEM_DEPTH  = 2 ** ADDR_W;

  // Input command codes
  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_CLOSE = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic in_open;
    logic apply;
    logic emit_reject;
    logic emit_marker;
    logic emit_value;
    logic fill;
    logic clear_batch;
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic item_valid;
    logic out_free;
    logic reject;
    logic apply_may_emit;
    logic apply_batch_end;
    logic emit_last;
    logic emit_done;
    logic emit_refill;
  } dp_sts_t;

endpackage

// ----- sv/kwsm_in_if.sv -----
// Input item channel: valid/ready handshake with command, lane and value.
// Depends on kwsm_pkg for field widths.
`timescale 1ns / 1ps

interface kwsm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 command;
  logic [kwsm_pkg::LANE_W-1:0]          lane;
  logic signed [kwsm_pkg::VALUE_W-1:0]  value;

  modport source (output valid, command, lane, value, input ready);
  modport sink   (input valid, command, lane, value, output ready);
endinterface

// ----- sv/kwsm_out_if.sv -----
// Result item channel: valid/ready handshake with merged value and flags.
// Depends on kwsm_pkg for field widths.
`timescale 1ns / 1ps

interface kwsm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [kwsm_pkg::VALUE_W-1:0]  merged_value;
  logic [kwsm_pkg::LANE_W-1:0]          source_lane;
  logic                                 last_of_run;
  logic                                 batch_done;
  logic                                 rejected;

  modport source (output valid, merged_value, source_lane, last_of_run, batch_done, rejected,
                  input ready);
  modport sink   (input valid, merged_value, source_lane, last_of_run, batch_done, rejected,
                  output ready);
endinterface

// ----- sv/kwsm_datapath.sv -----
// Datapath: lane FIFOs (shared memory plus head registers), head minimum select,
// and the result register. Depends on kwsm_pkg, kwsm_in_if, kwsm_out_if.
`timescale 1ns / 1ps

module kwsm_datapath (
  input  logic                clk,
  input  logic                rst,
  input  kwsm_pkg::ctl_cmd_t  cmd,
  output kwsm_pkg::dp_sts_t   sts,
  kwsm_in_if.sink             items,
  kwsm_out_if.source          results
);
  import kwsm_pkg::*;

  localparam int SLOTS = 2 ** LANE_W;

  typedef logic [CNT_W-1:0]          cnt_t;
  typedef cnt_t [LANES-1:0]          cnt_vec_t;
  typedef logic [PTR_W-1:0]          ptr_t;

  typedef struct packed {
    logic                       v;
    logic signed [VALUE_W-1:0]  val;
    logic [LANE_W-1:0]          idx;
  } cand_t;

  // Emission allowed: something held and no open lane empty
  function automatic logic may_emit(input cnt_vec_t c, input logic [LANES-1:0] cl);
    logic any;
    logic blocked;
    any     = 1'b0;
    blocked = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      if (c[i] != '0) any = 1'b1;
      else if (!cl[i]) blocked = 1'b1;
    end
    return any && !blocked;
  endfunction

  // Batch over: every lane closed and empty
  function automatic logic batch_complete(input cnt_vec_t c, input logic [LANES-1:0] cl);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < LANES; i++) begin
      if (!cl[i] || c[i] != '0) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic ptr_t bump(input ptr_t p);
    return (p == PTR_W'(LANE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Later candidate wins ties, so the higher lane goes first
  function automatic cand_t pick(input cand_t a, input cand_t b);
    return (b.v && (!a.v || b.val <= a.val)) ? b : a;
  endfunction

  // Item registers
  logic                       cmd_q;
  logic [LANE_W-1:0]          lane_q;
  logic signed [VALUE_W-1:0]  value_q;

  // Lane state
  cnt_vec_t                   cnt;
  ptr_t                       rdp [LANES];
  ptr_t                       wrp [LANES];
  logic [LANES-1:0]           closed;
  logic signed [VALUE_W-1:0]  head [LANES];
  logic [LANE_IDX_W-1:0]      best_q;

  // Lane storage
  logic [VALUE_W-1:0]         mem [MEM_DEPTH];
  logic [VALUE_W-1:0]         mem_q;

  // Result register
  logic                       out_valid;
  logic signed [VALUE_W-1:0]  out_value;
  logic [LANE_W-1:0]          out_lane;
  logic                       out_last;
  logic                       out_done;
  logic                       out_rej;

  logic                       item_take;
  logic                       in_range;
  logic [LANE_IDX_W-1:0]      lidx;
  logic                       reject;
  logic                       do_push;
  cnt_vec_t                   cnt_a;
  logic [LANES-1:0]           closed_a;
  cand_t                      cand [SLOTS];
  cand_t                      win_lo;
  cand_t                      win_hi;
  cand_t                      best;
  logic [LANE_IDX_W-1:0]      bidx;
  cnt_vec_t                   cnt_e;
  logic                       out_free;

  assign items.ready = cmd.in_open;
  assign item_take   = items.valid && items.ready;

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (item_take) begin
      cmd_q   <= items.command;
      lane_q  <= items.lane;
      value_q <= items.value;
    end
  end

  // Decode the held item against lane state
  always_comb begin
    in_range = {1'b0, lane_q} < (LANE_W + 1)'(LANES);
    lidx     = lane_q[LANE_IDX_W-1:0];
    reject   = (cmd_q == CMD_PUSH) &&
               (!in_range || closed[lidx] || cnt[lidx] >= CNT_W'(LANE_DEPTH));
    do_push  = cmd.apply && (cmd_q == CMD_PUSH) && !reject;
    for (int i = 0; i < LANES; i++) begin
      cnt_a[i]    = cnt[i];
      closed_a[i] = closed[i];
      if (in_range && lidx == LANE_IDX_W'(i)) begin
        if (cmd_q == CMD_PUSH) cnt_a[i] = cnt[i] + 1'b1;
        else closed_a[i] = 1'b1;
      end
    end
  end

  // Select the minimum head over a two-level tree
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      cand[s].idx = LANE_W'(s);
      if (s < LANES) begin
        cand[s].v   = cnt[s] != '0;
        cand[s].val = head[s];
      end else begin
        cand[s].v   = 1'b0;
        cand[s].val = '0;
      end
    end
    win_lo = pick(cand[0], cand[1]);
    win_hi = pick(cand[2], cand[3]);
    best   = pick(win_lo, win_hi);
    bidx   = best.idx[LANE_IDX_W-1:0];
    for (int i = 0; i < LANES; i++) begin
      cnt_e[i] = (bidx == LANE_IDX_W'(i)) ? cnt[i] - 1'b1 : cnt[i];
    end
  end

  assign out_free = !out_valid || results.ready;

  always_comb begin
    sts.item_valid      = items.valid;
    sts.out_free        = out_free;
    sts.reject          = reject;
    sts.apply_may_emit  = may_emit(cnt_a, closed_a);
    sts.apply_batch_end = batch_complete(cnt_a, closed_a);
    sts.emit_last       = !may_emit(cnt_e, closed);
    sts.emit_done       = batch_complete(cnt_e, closed);
    sts.emit_refill     = cnt_e[bidx] != '0;
  end

  // Lane control state: clear on reset or at batch end, push, close, pop
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_batch) begin
      cnt    <= '0;
      closed <= '0;
      for (int i = 0; i < LANES; i++) begin
        rdp[i] <= '0;
        wrp[i] <= '0;
      end
    end else if (cmd.apply) begin
      if (do_push) begin
        wrp[lidx] <= bump(wrp[lidx]);
        cnt[lidx] <= cnt[lidx] + 1'b1;
      end else if (cmd_q == CMD_CLOSE && in_range) begin
        closed[lidx] <= 1'b1;
      end
    end else if (cmd.emit_value) begin
      rdp[bidx] <= bump(rdp[bidx]);
      cnt[bidx] <= cnt_e[bidx];
    end
  end

  // Head registers: load on push into empty lane, refill from memory after pop
  always_ff @(posedge clk) begin
    if (do_push && cnt[lidx] == '0) head[lidx] <= value_q;
    else if (cmd.fill) head[best_q] <= mem_q;
    if (cmd.emit_value) best_q <= bidx;
  end

  // Lane memory: write on push, read next head on pop
  always_ff @(posedge clk) begin
    if (do_push) mem[{lidx, wrp[lidx]}] <= value_q;
    if (cmd.emit_value) mem_q <= mem[{bidx, bump(rdp[bidx])}];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_reject || cmd.emit_marker || cmd.emit_value) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_reject) begin
      out_value <= value_q;
      out_lane  <= lane_q;
      out_last  <= 1'b1;
      out_done  <= 1'b0;
      out_rej   <= 1'b1;
    end else if (cmd.emit_marker) begin
      out_value <= '0;
      out_lane  <= '0;
      out_last  <= 1'b1;
      out_done  <= 1'b1;
      out_rej   <= 1'b0;
    end else if (cmd.emit_value) begin
      out_value <= best.val;
      out_lane  <= best.idx;
      out_last  <= sts.emit_last;
      out_done  <= sts.emit_last && sts.emit_done;
      out_rej   <= 1'b0;
    end
  end

  assign results.valid        = out_valid;
  assign results.merged_value = out_value;
  assign results.source_lane  = out_lane;
  assign results.last_of_run  = out_last;
  assign results.batch_done   = out_done;
  assign results.rejected     = out_rej;

endmodule

// ----- sv/kwsm_ctrl.sv -----
// Controller: sequences accept, apply, per-value select and head refill.
// Depends on kwsm_pkg.
`timescale 1ns / 1ps

module kwsm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  kwsm_pkg::dp_sts_t   sts,
  output kwsm_pkg::ctl_cmd_t  cmd
);
  import kwsm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_APPLY = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;
  localparam logic [1:0] ST_FILL  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       last_run;
  logic       last_run_next;

  always_comb begin
    cmd           = '0;
    state_next    = state;
    last_run_next = last_run;
    unique case (state)
      ST_IDLE: begin
        cmd.in_open = 1'b1;
        if (sts.item_valid) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (sts.out_free) begin
          if (sts.reject) begin
            cmd.emit_reject = 1'b1;
            state_next      = ST_IDLE;
          end else begin
            cmd.apply = 1'b1;
            if (sts.apply_may_emit) begin
              state_next = ST_EMIT;
            end else begin
              // Batch ended with nothing to emit: send the marker
              cmd.emit_marker = sts.apply_batch_end;
              cmd.clear_batch = sts.apply_batch_end;
              state_next      = ST_IDLE;
            end
          end
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_value = 1'b1;
          last_run_next  = sts.emit_last;
          if (sts.emit_refill) begin
            state_next = ST_FILL;
          end else if (sts.emit_last) begin
            cmd.clear_batch = sts.emit_done;
            state_next      = ST_IDLE;
          end
        end
      end
      ST_FILL: begin
        cmd.fill   = 1'b1;
        state_next = last_run ? ST_IDLE : ST_EMIT;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      last_run <= 1'b0;
    end else begin
      state    <= state_next;
      last_run <= last_run_next;
    end
  end

endmodule

// ----- sv/k_way_sorted_merge.sv -----
// K-way merge of ascending signed 32-bit lanes into one ascending stream.
// Each item pushes a value into one of four 16-deep lanes or closes a lane. An item is
// accepted, then applied; after it, each emitted value takes a head compare-and-select
// over the lane heads, then a reload of that lane's head from the single-port lane
// memory, with the reload skipped when the popped lane goes empty. Equal heads
// leave the higher lane first. A push to a full or closed lane yields one rejected result.
// When all lanes are closed and drained the last result carries batch_done and the lanes
// reopen. The result register stalls the block while a result waits to be taken.
`timescale 1ns / 1ps

module k_way_sorted_merge (
  input logic        clk,
  input logic        rst,
  kwsm_in_if.sink    items,
  kwsm_out_if.source results
);
  import kwsm_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  kwsm_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  kwsm_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .items   (items),
    .results (results)
  );

`include "k_way_sorted_merge_assert.svh"

  `KWSM_ASSERT_IMP(a_rej_last, results.valid && results.rejected, results.last_of_run && !results.batch_done)
  `KWSM_ASSERT_IMP(a_done_last, results.valid && results.batch_done, results.last_of_run && !results.rejected)
  `KWSM_ASSERT_NXT(a_one_item, items.valid && items.ready, !items.ready)
  `KWSM_ASSERT_IMP(a_no_take_busy, cmd.emit_value, !cmd.in_open && !cmd.apply)

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the k-way sorted merge block.
// Depends on kwsm_pkg, the kwsm_in_if / kwsm_out_if interfaces and k_way_sorted_merge.
`timescale 1ns / 1ps

module testbench;
  import kwsm_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 144;
  localparam int PHASE_ITEMS  = 37;
  localparam int MAX_REPORTS  = 60;

  typedef struct {
    logic                      command;
    logic [LANE_W-1:0]         lane;
    logic signed [VALUE_W-1:0] value;
  } merge_item_t;

  typedef struct {
    logic signed [VALUE_W-1:0] merged_value;
    logic [LANE_W-1:0]         source_lane;
    logic                      last_of_run;
    logic                      batch_done;
    logic                      rejected;
  } merge_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kwsm_in_if  items_if ();
  kwsm_out_if results_if ();

  k_way_sorted_merge uut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if)
  );

  // Stimulus and expectation stores
  merge_item_t   items_to_send[$];
  merge_result_t merge_expected[$];

  // Predictor copy of the lane FIFOs
  logic signed [VALUE_W-1:0] lane_mem[LANES][LANE_DEPTH];
  int                        held[LANES];
  int                        rd_idx[LANES];
  int                        wr_idx[LANES];
  bit                        shut[LANES];

  int errors        = 0;
  int cycle_count   = 0;
  int taken_count   = 0;
  int random_added  = 0;
  bit item_taken    = 1'b0;
  bit draining      = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Emission may proceed while something is held and no open lane is empty
  function automatic bit heads_ready();
    bit any;
    any = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      if (held[i] > 0) any = 1'b1;
      else if (!shut[i]) return 1'b0;
    end
    return any;
  endfunction

  function automatic bit all_lanes_done();
    for (int i = 0; i < LANES; i++)
      if (!shut[i] || held[i] != 0) return 1'b0;
    return 1'b1;
  endfunction

  // Apply one item to the lane model and queue the results it causes
  task automatic predict_merge(input merge_item_t it);
    merge_result_t             run[$];
    merge_result_t             r;
    int                        best;
    logic signed [VALUE_W-1:0] best_val;
    int                        ln;
    ln = int'(it.lane);
    if (it.command == CMD_PUSH &&
        (ln >= LANES || shut[ln] || held[ln] >= LANE_DEPTH)) begin
      // refused push: echo the dropped value, nothing else moves
      r = '{it.value, it.lane, 1'b1, 1'b0, 1'b1};
      merge_expected.push_back(r);
    end else begin
      if (it.command == CMD_PUSH) begin
        lane_mem[ln][wr_idx[ln]] = it.value;
        wr_idx[ln] = (wr_idx[ln] + 1) % LANE_DEPTH;
        held[ln]++;
      end else if (ln < LANES) begin
        shut[ln] = 1'b1;
      end
      // pop the smallest head; later lane wins ties
      while (heads_ready()) begin
        best = -1;
        best_val = '0;
        for (int i = 0; i < LANES; i++) begin
          if (held[i] > 0 && (best < 0 || lane_mem[i][rd_idx[i]] <= best_val)) begin
            best = i;
            best_val = lane_mem[i][rd_idx[i]];
          end
        end
        r = '{best_val, LANE_W'(best), 1'b0, 1'b0, 1'b0};
        run.push_back(r);
        rd_idx[best] = (rd_idx[best] + 1) % LANE_DEPTH;
        held[best]--;
      end
      // close out the batch and reopen every lane
      if (all_lanes_done()) begin
        if (run.size() == 0) begin
          r = '{'0, '0, 1'b1, 1'b1, 1'b0};
          run.push_back(r);
        end else begin
          run[run.size()-1].batch_done = 1'b1;
        end
        for (int i = 0; i < LANES; i++) begin
          shut[i] = 1'b0;
          held[i] = 0;
          rd_idx[i] = 0;
          wr_idx[i] = 0;
        end
      end
      if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
      foreach (run[k]) merge_expected.push_back(run[k]);
    end
  endtask

  task automatic add_item(input logic cmd, input int ln, input logic signed [VALUE_W-1:0] val);
    merge_item_t it;
    it = '{cmd, LANE_W'(ln), val};
    items_to_send.push_back(it);
  endtask

  // One batch of ascending lanes, interleaved, with some stray items mixed in
  task automatic add_batch();
    int                        left[LANES];
    bit                        closed_here[LANES];
    logic signed [VALUE_W-1:0] cur[LANES];
    logic signed [VALUE_W-1:0] base;
    int                        step_max;
    int                        open_lanes;
    int                        ln;
    bit                        tie_mode;
    base = $urandom;
    tie_mode = ($urandom_range(2) == 0);
    step_max = tie_mode ? 1 : (1 << $urandom_range(20));
    open_lanes = LANES;
    for (int i = 0; i < LANES; i++) begin
      left[i] = ($urandom_range(9) == 0) ? $urandom_range(LANE_DEPTH) : $urandom_range(5);
      closed_here[i] = 1'b0;
      cur[i] = tie_mode ? base : base + $urandom_range(1000);
    end
    while (open_lanes > 0) begin
      if ($urandom_range(9) == 0) begin
        add_item(logic'($urandom_range(1)), $urandom_range(LANES - 1), $urandom);
        random_added++;
      end
      ln = $urandom_range(LANES - 1);
      if (!closed_here[ln]) begin
        if (left[ln] > 0) begin
          add_item(CMD_PUSH, ln, cur[ln]);
          cur[ln] = cur[ln] + $urandom_range(step_max);
          left[ln]--;
        end else begin
          add_item(CMD_CLOSE, ln, $urandom);
          closed_here[ln] = 1'b1;
          open_lanes--;
        end
        random_added++;
      end
    end
  endtask

  // Driver: present items and the receiver's ready on the falling edge
  always @(negedge clk) begin
    merge_item_t nxt;
    int          send_idle;
    int          recv_stall;
    unique case ((taken_count / PHASE_ITEMS) % 4)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 58; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 58; end
      default: begin send_idle = 11; recv_stall = 11; end
    endcase
    if (!rst) begin
      if (!items_if.valid || item_taken) begin
        if (items_to_send.size() > 0 && $urandom_range(99) >= send_idle) begin
          nxt = items_to_send.pop_front();
          items_if.valid   <= 1'b1;
          items_if.command <= nxt.command;
          items_if.lane    <= nxt.lane;
          items_if.value   <= nxt.value;
        end else begin
          items_if.valid <= 1'b0;
        end
      end
      results_if.ready <= draining || ($urandom_range(99) >= recv_stall);
    end
  end

  // Monitor: predict on accepted items, check accepted results
  // (reports give value/lane/last/done/rej)
  always @(posedge clk) begin
    merge_item_t   got_item;
    merge_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      item_taken = !rst && items_if.valid && items_if.ready;
      if (item_taken) begin
        got_item = '{items_if.command, items_if.lane, items_if.value};
        predict_merge(got_item);
        taken_count++;
      end
      if (!rst && results_if.valid && results_if.ready) begin
        if (merge_expected.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: expected nothing, actual %0d/%0d/%b/%b/%b",
                     $time, results_if.merged_value, results_if.source_lane,
                     results_if.last_of_run, results_if.batch_done, results_if.rejected);
        end else begin
          want = merge_expected.pop_front();
          if (results_if.merged_value !== want.merged_value ||
              results_if.source_lane !== want.source_lane ||
              results_if.last_of_run !== want.last_of_run ||
              results_if.batch_done !== want.batch_done ||
              results_if.rejected !== want.rejected) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: expected %0d/%0d/%b/%b/%b, actual %0d/%0d/%b/%b/%b",
                       $time, want.merged_value, want.source_lane, want.last_of_run,
                       want.batch_done, want.rejected, results_if.merged_value,
                       results_if.source_lane, results_if.last_of_run,
                       results_if.batch_done, results_if.rejected);
          end
        end
      end
    end
  end

  initial begin
    items_if.valid   = 1'b0;
    items_if.command = CMD_PUSH;
    items_if.lane    = '0;
    items_if.value   = '0;
    results_if.ready = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      held[i] = 0;
      rd_idx[i] = 0;
      wr_idx[i] = 0;
      shut[i] = 1'b0;
    end

    // empty batch: repeated close, then a marker on the last close
    add_item(CMD_CLOSE, 0, 0);
    add_item(CMD_CLOSE, 0, 0);
    add_item(CMD_CLOSE, 1, 0);
    add_item(CMD_CLOSE, 2, 0);
    add_item(CMD_CLOSE, 3, 0);
    // fill one lane to the brim, spanning both value extremes, then overflow it
    for (int k = 0; k < LANE_DEPTH; k++)
      add_item(CMD_PUSH, 1, (k == 0) ? 32'sh80000000 :
                            (k == LANE_DEPTH - 1) ? 32'sh7fffffff : (k * 1000 - 7000));
    add_item(CMD_PUSH, 1, -1);
    // push into a closed lane, then let the full lane drain
    add_item(CMD_CLOSE, 0, 0);
    add_item(CMD_CLOSE, 2, 0);
    add_item(CMD_PUSH, 2, 32'sh5a5a5a5a);
    add_item(CMD_CLOSE, 3, 0);

    while (random_added < RANDOM_ITEMS) add_batch();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait for the last item, every result, then a quiet tail
    while (items_to_send.size() > 0 || items_if.valid) @(posedge clk);
    while (merge_expected.size() > 0) @(posedge clk);
    draining = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && merge_expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
